>>> design/tccc_pkg.sv
// Shared types and constants of the text console cursor controller.
`default_nettype none
package tccc_pkg;

    localparam int TAB_STOP    = 4;
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 256;

    localparam int COLS_W = 10;
    localparam int ROWS_W = 9;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Cell operations
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_DRAW     = 3'd1;
    localparam logic [2:0] OP_CLR_CELL = 3'd2;
    localparam logic [2:0] OP_SCROLL   = 3'd3;
    localparam logic [2:0] OP_CLR_SCR  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 2'd2;

    // Control characters
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_PRINT_LO  = 8'd32;
    localparam logic [7:0] CH_PRINT_HI  = 8'd128;

    localparam logic [COLS_W-1:0] RST_COLUMNS = 10'd80;
    localparam logic [ROWS_W-1:0] RST_ROWS    = 9'd25;
    localparam logic [31:0]       RST_COLOR   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [8:0] target_col;
        logic [7:0] target_row;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  op;
        logic [8:0]  cell_col;
        logic [7:0]  cell_row;
        logic [6:0]  glyph_code;
        logic [31:0] glyph_color;
        logic [8:0]  cursor_col_now;
        logic [7:0]  cursor_row_now;
        logic        last;
    } t_out_item;

    // One classified item: its first result and whether a scroll follows
    typedef struct packed {
        logic [2:0]  op;
        logic [8:0]  cell_col;
        logic [7:0]  cell_row;
        logic [6:0]  glyph_code;
        logic [31:0] glyph_color;
        logic [8:0]  cursor_col;
        logic [7:0]  cursor_row;
        logic        scroll_next;
    } t_job;

endpackage
`default_nettype wire

>>> design/tccc_front.sv
// Front end: configuration registers, cursor state and item classification.
`default_nettype none
module tccc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tccc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tccc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_push,
    input  wire tccc_pkg::t_in_item             i_item,
    output tccc_pkg::t_job                      o_job
);
    import tccc_pkg::*;

    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic [31:0]       r_color;
    logic [COLS_W-1:0] r_col, n_col;
    logic [ROWS_W-1:0] r_row, n_row;

    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W:0]   col_a;
    logic [ROWS_W:0]   row_a;
    logic              scroll;
    t_job              job;

    always_comb begin
        if (r_cols == '0) begin
            cols_eff = COLS_W'(1);
        end else if (r_cols > COLS_W'(MAX_COLUMNS)) begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end else begin
            cols_eff = r_cols;
        end
        if (r_rows == '0) begin
            rows_eff = ROWS_W'(1);
        end else if (r_rows > ROWS_W'(MAX_ROWS)) begin
            rows_eff = ROWS_W'(MAX_ROWS);
        end else begin
            rows_eff = r_rows;
        end
    end

    always_comb begin
        col_a  = {1'b0, r_col};
        row_a  = {1'b0, r_row};
        scroll = 1'b0;
        job    = '0;
        job.op = OP_NONE;
        unique case (i_item.kind)
            KIND_CHAR: begin
                priority if (i_item.char_code == CH_NEWLINE) begin
                    col_a = '0;
                    row_a = row_a + 1'b1;
                end else if (i_item.char_code == CH_BACKSPACE) begin
                    if (r_col != '0) begin
                        col_a        = {1'b0, r_col} - 1'b1;
                        job.op       = OP_CLR_CELL;
                        job.cell_col = col_a[8:0];
                        job.cell_row = r_row[7:0];
                    end
                end else if (i_item.char_code == CH_TAB) begin
                    col_a = {1'b0, r_col} + (COLS_W+1)'(TAB_STOP)
                            - (COLS_W+1)'(r_col % TAB_STOP);
                end else if (i_item.char_code >= CH_PRINT_LO
                             && i_item.char_code < CH_PRINT_HI) begin
                    job.op          = OP_DRAW;
                    job.cell_col    = r_col[8:0];
                    job.cell_row    = r_row[7:0];
                    job.glyph_code  = i_item.char_code[6:0];
                    job.glyph_color = r_color;
                    col_a           = {1'b0, r_col} + 1'b1;
                end else begin
                end
                // wrap, then scroll
                if (col_a >= {1'b0, cols_eff}) begin
                    col_a = '0;
                    row_a = row_a + 1'b1;
                end
                if (row_a >= {1'b0, rows_eff}) begin
                    scroll = 1'b1;
                    row_a  = {1'b0, rows_eff} - 1'b1;
                    col_a  = '0;
                end
            end
            KIND_SET: begin
                if ({1'b0, i_item.target_col} < cols_eff
                    && {1'b0, i_item.target_row} < rows_eff) begin
                    col_a = (COLS_W+1)'(i_item.target_col);
                    row_a = (ROWS_W+1)'(i_item.target_row);
                end
            end
            KIND_CLEAR: begin
                job.op = OP_CLR_SCR;
                col_a  = '0;
                row_a  = '0;
            end
            default: begin
            end
        endcase
        // a scroll on its own becomes the first result
        if (scroll && job.op == OP_NONE) begin
            job.op          = OP_SCROLL;
            job.scroll_next = 1'b0;
        end else begin
            job.scroll_next = scroll;
        end
        job.cursor_col = col_a[8:0];
        job.cursor_row = row_a[7:0];
        n_col = col_a[COLS_W-1:0];
        n_row = row_a[ROWS_W-1:0];
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= RST_COLUMNS;
            r_rows  <= RST_ROWS;
            r_color <= RST_COLOR;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_COLUMNS: r_cols  <= i_cfg_data[COLS_W-1:0];
                    REG_ROWS:    r_rows  <= i_cfg_data[ROWS_W-1:0];
                    REG_COLOR:   r_color <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (i_push) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/tccc_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module tccc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tccc_pkg::t_job i_job,
    input  wire logic           i_pop,
    output tccc_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);
    import tccc_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/tccc_back.sv
// Back end: expands each classified item into its results and holds the output register.
`default_nettype none
module tccc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tccc_pkg::t_job i_job,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output tccc_pkg::t_out_item o_out_item
);
    import tccc_pkg::*;

    logic      r_valid;
    logic      r_second;
    t_out_item r_item;
    logic      load;
    logic      is_last;
    t_out_item n_item;

    assign load    = (!r_valid || !i_out_stall) && !i_empty;
    assign is_last = !i_job.scroll_next || r_second;
    assign o_pop   = load && is_last;

    always_comb begin
        n_item                = '0;
        n_item.cursor_col_now = i_job.cursor_col;
        n_item.cursor_row_now = i_job.cursor_row;
        n_item.last           = is_last;
        if (r_second) begin
            n_item.op = OP_SCROLL;
        end else begin
            n_item.op          = i_job.op;
            n_item.cell_col    = i_job.cell_col;
            n_item.cell_row    = i_job.cell_row;
            n_item.glyph_code  = i_job.glyph_code;
            n_item.glyph_color = i_job.glyph_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= !is_last;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule
`default_nettype wire

>>> design/text_console_cursor_controller_top.sv
// Top level of the text console cursor controller.
//
//  channel   direction  handshake                payload
//  -------   ---------  -----------------------  --------------------------
//  in        input      i_in_valid / o_in_stall  i_in_item  (t_in_item)
//  out       output     o_out_valid/ i_out_stall o_out_item (t_out_item)
//  cfg       input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// An item is taken every cycle while the two-entry queue has room; the back
// end sends one result per cycle while the output is not stalled. An item gives
// one result, or two when it draws or clears a cell and also scrolls. Its first
// result is written into the queue and then into the back end's output register.
// Reset clears the cursor and queue and restores the register defaults. A stalled
// output holds; the queue fills and then stalls the input.
`default_nettype none
module text_console_cursor_controller_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire tccc_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output tccc_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [tccc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tccc_pkg::CFG_W-1:0]     i_cfg_data
);
    import tccc_pkg::*;

    t_job front_job;
    t_job head_job;
    logic push, pop, q_empty, q_full;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    tccc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_in_item),
        .o_job       (front_job)
    );

    tccc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tccc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the text console cursor controller: directed table, then random traffic.
module tb_top;
    import tccc_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_PCT    = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_CAP  = 40;

    typedef struct {
        bit          is_setup;
        int          cols;
        int          rows;
        logic [31:0] colour;
        t_in_item    stim;
        bit          typed;
        t_out_item   want;
    } t_script_row;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_COLUMNS;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predicted cursor and screen registers
    logic [COLS_W-1:0] cur_col    = '0;
    logic [ROWS_W-1:0] cur_row    = '0;
    logic [COLS_W-1:0] cfg_cols   = RST_COLUMNS;
    logic [ROWS_W-1:0] cfg_rows   = RST_ROWS;
    logic [31:0]       cfg_colour = RST_COLOR;
    t_out_item         step_out [2];

    t_out_item   pending_ops [$];
    t_script_row script [$];

    int err_count       = 0;
    int items_sent      = 0;
    int directed_items  = 0;
    int results_checked = 0;
    int scrolls_seen    = 0;
    int setups_loaded   = 0;
    int cycles          = 0;
    int hold_requests   = 0;
    int holds_started   = 0;
    int hold_left       = 0;
    bit sender_calm     = 1'b0;
    bit sink_calm       = 1'b0;

    text_console_cursor_controller_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int screen_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(cfg_cols);
    endfunction

    function automatic int screen_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_ROWS) return MAX_ROWS;
        return int'(cfg_rows);
    endfunction

    function automatic t_out_item cell_op(logic [2:0] op, int col, int row,
                                          logic [6:0] glyph, logic [31:0] colour);
        t_out_item r;
        r             = '0;
        r.op          = op;
        r.cell_col    = 9'(col);
        r.cell_row    = 8'(row);
        r.glyph_code  = glyph;
        r.glyph_color = colour;
        return r;
    endfunction

    // Advance the cursor for one item and fill step_out with its cell operations
    function automatic int predict_cell_ops(t_in_item it);
        int cols;
        int rows;
        int col;
        int row;
        int n;
        cols = screen_cols();
        rows = screen_rows();
        col  = int'(cur_col);
        row  = int'(cur_row);
        n    = 0;
        case (it.kind)
            KIND_CHAR: begin
                if (it.char_code == CH_NEWLINE) begin
                    col = 0;
                    row++;
                end else if (it.char_code == CH_BACKSPACE) begin
                    if (col > 0) begin
                        col--;
                        step_out[n] = cell_op(OP_CLR_CELL, col, row, '0, '0);
                        n++;
                    end
                end else if (it.char_code == CH_TAB) begin
                    col = col + TAB_STOP - col % TAB_STOP;
                end else if (it.char_code >= CH_PRINT_LO && it.char_code < CH_PRINT_HI) begin
                    step_out[n] = cell_op(OP_DRAW, col, row, it.char_code[6:0], cfg_colour);
                    n++;
                    col++;
                end
                // wrap applies to any byte, even one that moved nothing
                if (col >= cols) begin
                    col = 0;
                    row++;
                end
                if (row >= rows) begin
                    step_out[n] = cell_op(OP_SCROLL, 0, 0, '0, '0);
                    n++;
                    row = rows - 1;
                    col = 0;
                end
            end
            KIND_SET: begin
                if (int'(it.target_col) < cols && int'(it.target_row) < rows) begin
                    col = int'(it.target_col);
                    row = int'(it.target_row);
                end
            end
            KIND_CLEAR: begin
                step_out[n] = cell_op(OP_CLR_SCR, 0, 0, '0, '0);
                n++;
                col = 0;
                row = 0;
            end
            default: ;
        endcase
        if (n == 0) begin
            step_out[n] = cell_op(OP_NONE, 0, 0, '0, '0);
            n++;
        end
        cur_col = COLS_W'(col);
        cur_row = ROWS_W'(row);
        for (int i = 0; i < n; i++) begin
            step_out[i].cursor_col_now = 9'(col);
            step_out[i].cursor_row_now = 8'(row);
            step_out[i].last           = (i == n - 1);
        end
        return n;
    endfunction

    function automatic t_in_item in_of(logic [1:0] kind, logic [7:0] ch,
                                       logic [8:0] tcol, logic [7:0] trow);
        t_in_item it;
        it.kind       = kind;
        it.char_code  = ch;
        it.target_col = tcol;
        it.target_row = trow;
        return it;
    endfunction

    function automatic t_out_item res_of(logic [2:0] op, int ccol, int crow, logic [6:0] glyph,
                                         logic [31:0] colour, int kcol, int krow);
        t_out_item r;
        r                = cell_op(op, ccol, crow, glyph, colour);
        r.cursor_col_now = 9'(kcol);
        r.cursor_row_now = 8'(krow);
        r.last           = 1'b1;
        return r;
    endfunction

    function automatic void script_item(t_in_item stim, bit typed = 1'b0,
                                        t_out_item want = '0);
        t_script_row r;
        r          = '{default: '0};
        r.stim     = stim;
        r.typed    = typed;
        r.want     = want;
        script.push_back(r);
    endfunction

    function automatic void script_setup(int cols, int rows, logic [31:0] colour);
        t_script_row r;
        r          = '{default: '0};
        r.is_setup = 1'b1;
        r.cols     = cols;
        r.rows     = rows;
        r.colour   = colour;
        script.push_back(r);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        it.kind       = KIND_CHAR;
        it.char_code  = 8'($urandom);
        it.target_col = 9'($urandom);
        it.target_row = 8'($urandom);
        pick          = $urandom_range(99);
        if (pick < 48) begin
            it.char_code = 8'($urandom_range(32, 127));
        end else if (pick < 56) begin
            it.char_code = CH_NEWLINE;
        end else if (pick < 65) begin
            it.char_code = CH_BACKSPACE;
        end else if (pick < 73) begin
            it.char_code = CH_TAB;
        end else if (pick < 88) begin
            it.kind = KIND_SET;
            // mostly on screen; the rest keep their random, often off-screen, target
            if (pick < 84) begin
                it.target_col = 9'($urandom_range(screen_cols() - 1));
                it.target_row = 8'($urandom_range(screen_rows() - 1));
            end
        end else if (pick < 93) begin
            it.kind = KIND_CLEAR;
        end else if (pick < 95) begin
            it.kind = KIND_SPARE;
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (err_count < REPORT_CAP) begin
            $display("MISMATCH after %0d results, %s: got 0x%0h, want 0x%0h",
                     results_checked, what, got, want);
        end
        err_count++;
    endtask

    // Offer one item, entered and left at a falling edge
    task automatic offer_item(t_in_item it, bit typed, t_out_item want);
        int n;
        while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        n = predict_cell_ops(it);
        if (typed) begin
            pending_ops.push_back(want);
        end else begin
            for (int i = 0; i < n; i++) pending_ops.push_back(step_out[i]);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained(int settle);
        in_valid <= 1'b0;
        while (pending_ops.size() != 0) @(posedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic load_screen(int cols, int rows, logic [31:0] colour);
        wait_drained(4);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLUMNS;
        cfg_data  <= CFG_W'(cols);
        @(negedge clk);
        cfg_index <= REG_ROWS;
        cfg_data  <= CFG_W'(rows);
        @(negedge clk);
        cfg_index <= REG_COLOR;
        cfg_data  <= colour;
        @(negedge clk);
        cfg_we     <= 1'b0;
        cfg_cols   = COLS_W'(cols);
        cfg_rows   = ROWS_W'(rows);
        cfg_colour = colour;
        setups_loaded++;
    endtask

    // Output side: random stalls, plus a long hold when one is requested
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_started != hold_requests) begin
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES - 1;
            out_stall     <= 1'b1;
        end else begin
            out_stall <= !sink_calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_ops.size() == 0) begin
                report_mismatch("result with nothing pending, op", out_item.op, OP_NONE);
            end else begin
                want = pending_ops.pop_front();
                if (out_item.op != want.op)
                    report_mismatch("op", out_item.op, want.op);
                if (out_item.cell_col != want.cell_col)
                    report_mismatch("cell_col", out_item.cell_col, want.cell_col);
                if (out_item.cell_row != want.cell_row)
                    report_mismatch("cell_row", out_item.cell_row, want.cell_row);
                if (out_item.glyph_code != want.glyph_code)
                    report_mismatch("glyph_code", out_item.glyph_code, want.glyph_code);
                if (out_item.glyph_color != want.glyph_color)
                    report_mismatch("glyph_color", out_item.glyph_color, want.glyph_color);
                if (out_item.cursor_col_now != want.cursor_col_now)
                    report_mismatch("cursor_col_now", out_item.cursor_col_now,
                                    want.cursor_col_now);
                if (out_item.cursor_row_now != want.cursor_row_now)
                    report_mismatch("cursor_row_now", out_item.cursor_row_now,
                                    want.cursor_row_now);
                if (out_item.last != want.last)
                    report_mismatch("last", out_item.last, want.last);
                if (want.op == OP_SCROLL) scrolls_seen++;
                results_checked++;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped: still waiting after %0d cycles", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_script_row entry;
        int          cols;
        int          rows;
        logic [31:0] colour;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset screen is 80 by 25 in white, cursor home
        script_item(in_of(KIND_SPARE, 8'hFF, 9'h1FF, 8'hFF), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 0, 0));
        script_item(in_of(KIND_CHAR, 8'd65, '0, '0), 1,
                    res_of(OP_DRAW, 0, 0, 7'd65, 32'hFFFF_FFFF, 1, 0));
        script_item(in_of(KIND_CHAR, 8'd0, '0, '0), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 1, 0));
        script_item(in_of(KIND_CHAR, 8'hFF, 9'h1FF, 8'hFF), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 1, 0));
        script_item(in_of(KIND_CHAR, CH_PRINT_HI, '0, '0), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 1, 0));
        script_item(in_of(KIND_CHAR, 8'd127, '0, '0), 1,
                    res_of(OP_DRAW, 1, 0, 7'd127, 32'hFFFF_FFFF, 2, 0));
        script_item(in_of(KIND_CHAR, CH_PRINT_LO, '0, '0), 1,
                    res_of(OP_DRAW, 2, 0, 7'd32, 32'hFFFF_FFFF, 3, 0));
        script_item(in_of(KIND_CHAR, 8'd31, '0, '0), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 3, 0));
        script_item(in_of(KIND_CHAR, CH_BACKSPACE, '0, '0), 1,
                    res_of(OP_CLR_CELL, 2, 0, 0, 0, 2, 0));
        script_item(in_of(KIND_CHAR, CH_TAB, '0, '0), 1, res_of(OP_NONE, 0, 0, 0, 0, 4, 0));
        script_item(in_of(KIND_CHAR, CH_TAB, '0, '0), 1, res_of(OP_NONE, 0, 0, 0, 0, 8, 0));
        script_item(in_of(KIND_CHAR, CH_NEWLINE, '0, '0), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 0, 1));
        script_item(in_of(KIND_CHAR, CH_BACKSPACE, '0, '0), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 0, 1));
        script_item(in_of(KIND_SET, '0, 9'd79, 8'd24), 1, res_of(OP_NONE, 0, 0, 0, 0, 79, 24));
        // draw in the bottom right corner: wraps and scrolls
        script_item(in_of(KIND_CHAR, 8'd122, '0, '0));
        script_item(in_of(KIND_SET, '0, 9'd80, 8'd0), 1, res_of(OP_NONE, 0, 0, 0, 0, 0, 24));
        script_item(in_of(KIND_SET, '0, 9'd0, 8'd25), 1, res_of(OP_NONE, 0, 0, 0, 0, 0, 24));
        script_item(in_of(KIND_CHAR, CH_NEWLINE, '0, '0), 1,
                    res_of(OP_SCROLL, 0, 0, 0, 0, 0, 24));
        script_item(in_of(KIND_SET, '0, 9'd76, 8'd24), 1, res_of(OP_NONE, 0, 0, 0, 0, 76, 24));
        script_item(in_of(KIND_CHAR, CH_TAB, '0, '0));
        script_item(in_of(KIND_CLEAR, 8'h5A, 9'h155, 8'hAA), 1,
                    res_of(OP_CLR_SCR, 0, 0, 0, 0, 0, 0));
        // zero geometry acts as a single cell
        script_setup(0, 0, 32'h0);
        script_item(in_of(KIND_CHAR, 8'd66, '0, '0));
        // oversized geometry clips to the largest screen
        script_setup(1023, 511, 32'h8000_0001);
        script_item(in_of(KIND_SET, '0, 9'd511, 8'd255), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 511, 255));
        script_item(in_of(KIND_CHAR, 8'd120, '0, '0));
        script_item(in_of(KIND_SET, '0, 9'd300, 8'd200), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 300, 200));
        // shrink under the cursor: it holds until the next character byte
        script_setup(10, 5, 32'h1234_5678);
        script_item(in_of(KIND_SET, '0, 9'd20, 8'd1), 1,
                    res_of(OP_NONE, 0, 0, 0, 0, 300, 200));
        script_item(in_of(KIND_CHAR, CH_TAB, '0, '0));

        for (int k = 0; k < script.size(); k++) begin
            entry = script[k];
            if (entry.is_setup) begin
                load_screen(entry.cols, entry.rows, entry.colour);
            end else begin
                offer_item(entry.stim, entry.typed, entry.want);
                directed_items++;
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    cols = 1;
                    rows = 1;
                    colour = 32'h0;
                end
                1: begin
                    cols = 1023;
                    rows = 511;
                    colour = 32'hFFFF_FFFF;
                end
                2: begin
                    cols = MAX_COLUMNS;
                    rows = MAX_ROWS;
                    colour = $urandom;
                end
                3: begin
                    cols = 16;
                    rows = 4;
                    colour = $urandom;
                end
                4: begin
                    cols = 2;
                    rows = 3;
                    colour = 32'h5555_AAAA;
                end
                default: begin
                    case ($urandom_range(4))
                        0: cols = $urandom_range(1, 8);
                        1: cols = $urandom_range(9, 120);
                        2: cols = 0;
                        3: cols = $urandom_range(513, 1023);
                        default: cols = $urandom_range(1, 512);
                    endcase
                    rows = ($urandom_range(3) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(1, 12);
                    colour = $urandom;
                end
            endcase
            load_screen(cols, rows, colour);
            // phase 3 holds the output off while items keep coming; phase 5 runs flat out
            sender_calm = (p == 3 || p == 5);
            sink_calm   = (p == 5);
            if (p == 3) hold_requests++;
            for (int k = 0; k < PHASE_ITEMS; k++) offer_item(random_item(), 1'b0, '0);
        end
        sender_calm = 1'b0;
        sink_calm   = 1'b0;

        wait_drained(10);
        if (pending_ops.size() != 0)
            report_mismatch("results never produced", pending_ops.size(), 0);

        $display("Run covered %0d items (%0d from the directed table) over %0d screen setups,",
                 items_sent, directed_items, setups_loaded);
        $display("with %0d results checked, %0d scrolls and %0d mismatches.",
                 results_checked, scrolls_seen, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
design/tccc_pkg.sv
design/tccc_front.sv
design/tccc_queue.sv
design/tccc_back.sv
design/text_console_cursor_controller_top.sv
verif/tb_top.sv
